[rtl/igfr_pkg.sv]
package igfr_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int FLEN_W       = 6;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;

	localparam logic [7:0] IDLE_RESET = 8'd30;
	localparam logic [7:0] IDLE_MAX   = 8'd255;

	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic RES_NOTICE = 1'b0;
	localparam logic RES_DATA   = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
		logic [7:0] tick_ms;
		logic [7:0] read_limit;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        data;
		logic [FLEN_W-1:0] frame_length;
		logic              last;
	} res_t;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_TICK,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] arg;
	} op_t;

	typedef enum logic {
		B_IDLE,
		B_READ
	} back_state_t;

endpackage

[rtl/igfr_front.sv]
module igfr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  igfr_pkg::item_t item,
	output logic           op_valid,
	input  logic           op_ready,
	output igfr_pkg::op_t  op
);
	import igfr_pkg::*;

	logic op_valid_s1;
	op_t  op_s1;
	logic accept;
	logic keep;
	op_t  decoded;

	assign item_stall = op_valid_s1 && !op_ready;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		keep    = 1'b1;
		decoded = '{kind: OP_BYTE, arg: item.rx_byte};
		unique case (item.cmd)
			CMD_BYTE: decoded = '{kind: OP_BYTE, arg: item.rx_byte};
			CMD_TICK: decoded = '{kind: OP_TICK, arg: item.tick_ms};
			CMD_READ: decoded = '{kind: OP_READ, arg: item.read_limit};
			default:  keep    = 1'b0;
		endcase
	end

	// drop the unused command here, it never reaches the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (accept) begin
			op_valid_s1 <= keep;
		end else if (op_ready) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			op_s1 <= decoded;
		end
	end

	assign op_valid = op_valid_s1;
	assign op       = op_s1;

endmodule

[rtl/igfr_queue.sv]
module igfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          ready,
	input  igfr_pkg::op_t push_op,
	output logic          valid,
	input  logic          pop,
	output igfr_pkg::op_t pop_op
);
	import igfr_pkg::*;

	op_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign ready   = fill_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign valid   = fill_q != '0;
	assign do_push = push && ready;
	assign do_pop  = pop && valid;
	assign pop_op  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (QPTR_W + 1)'(1);
			end else if (!do_push && do_pop) begin
				fill_q <= fill_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[rtl/igfr_back.sv]
module igfr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_pop,
	input  igfr_pkg::op_t  op,
	input  logic           idle_limit_we,
	input  logic [7:0]     idle_limit_wdata,
	output logic           res_valid,
	input  logic           res_stall,
	output igfr_pkg::res_t res
);
	import igfr_pkg::*;

	logic [7:0]       store_q [BUFFER_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] snap_q;
	logic [7:0]       idle_q;
	logic [7:0]       limit_q;
	back_state_t      state_q;
	back_state_t      state_d;
	logic [CNT_W-1:0] rd_len_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_valid_s1;
	logic [7:0]       rd_data_s1;
	logic             rd_last_s1;
	logic             res_valid_q;
	res_t             res_q;

	logic             out_free;
	logic [8:0]       tick_sum;
	logic [7:0]       tick_sat;
	logic             tick_emit;
	logic [CNT_W-1:0] read_len;
	logic             issue;
	logic             move;
	logic             read_done;
	logic             load_notice;

	assign out_free = !res_valid_q || !res_stall;
	assign tick_sum = {1'b0, idle_q} + {1'b0, op.arg};
	assign tick_sat = tick_sum[8] ? IDLE_MAX : tick_sum[7:0];
	assign tick_emit = (count_q != '0) && (snap_q == count_q) && (idle_q < limit_q)
		&& (tick_sat >= limit_q);
	assign read_len = (op.arg < 8'(count_q)) ? CNT_W'(op.arg) : count_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (op_pop && op.kind == OP_READ && read_len != '0) state_d = B_READ;
			B_READ: if (read_done) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		op_pop      = 1'b0;
		issue       = 1'b0;
		move        = 1'b0;
		read_done   = 1'b0;
		load_notice = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (op_valid) begin
					// a tick may need the output register, so wait for it
					op_pop      = (op.kind == OP_TICK) ? out_free : 1'b1;
					load_notice = op_pop && op.kind == OP_TICK && tick_emit;
				end
			end
			B_READ: begin
				move      = rd_valid_s1 && out_free;
				issue     = (rd_idx_q != rd_len_q) && (!rd_valid_s1 || out_free);
				read_done = (rd_idx_q == rd_len_q) && (!rd_valid_s1 || move);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			count_q     <= '0;
			snap_q      <= '0;
			idle_q      <= '0;
			limit_q     <= IDLE_RESET;
			rd_len_q    <= '0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idle_limit_we) begin
				limit_q <= idle_limit_wdata;
			end
			if (op_pop) begin
				case (op.kind)
					OP_BYTE: begin
						if (count_q < CNT_W'(BUFFER_DEPTH)) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					OP_TICK: begin
						if (count_q == '0) begin
							snap_q <= '0;
						end else if (snap_q != count_q) begin
							snap_q <= count_q;
							idle_q <= '0;
						end else if (idle_q < limit_q) begin
							idle_q <= tick_sat;
						end
					end
					OP_READ: begin
						count_q  <= '0;
						rd_len_q <= read_len;
						rd_idx_q <= '0;
					end
					default: ;
				endcase
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (load_notice || move) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && op.kind == OP_BYTE && count_q < CNT_W'(BUFFER_DEPTH)) begin
			store_q[count_q[ADDR_W-1:0]] <= op.arg;
		end
		if (issue) begin
			rd_data_s1 <= store_q[rd_idx_q[ADDR_W-1:0]];
			rd_last_s1 <= (rd_idx_q + CNT_W'(1)) == rd_len_q;
		end
		if (load_notice) begin
			res_q <= '{kind: RES_NOTICE, data: 8'd0,
				frame_length: FLEN_W'(count_q), last: 1'b1};
		end else if (move) begin
			res_q <= '{kind: RES_DATA, data: rd_data_s1,
				frame_length: '0, last: rd_last_s1};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_read_empties: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_READ |-> count_q == '0)
		else $error("store not emptied during read-out");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= rd_len_q)
		else $error("read index ran past read length");

	a_s1_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q == B_READ)
		else $error("read data stage occupied outside read-out");

	a_notice_limit: assert property (@(posedge clk) disable iff (!arst_n)
		load_notice && !idle_limit_we |=> idle_q >= limit_q)
		else $error("notice issued below idle limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |-> !(load_notice || move))
		else $error("output register overwritten while stalled");

endmodule

[rtl/idle_gap_frame_receiver.sv]
// channel  | valid      | stall      | payload
// ---------+------------+------------+-----------------------------
// item     | item_valid | item_stall | item  (cmd, rx_byte, tick_ms, read_limit)
// res      | res_valid  | res_stall  | res   (kind, data, frame_length, last)
// config   | idle_limit_we (no stall)  | idle_limit_wdata
//
// Byte and tick beats are taken one per cycle while item_stall is low; a decode stage
// and a two-entry queue sit before the store; a notice is offered from the output register.
// A read is popped from the queue, primes the registered read port, then streams
// one byte per cycle unless res stalls, via the read port and output registers.
// Reset clears counts, idle timer and limit (to 30); store contents stay undefined.
// A stall on res holds the output register and, once the queue fills, item_stall.
module idle_gap_frame_receiver (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  igfr_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_stall,
	output igfr_pkg::res_t res,
	input  logic           idle_limit_we,
	input  logic [7:0]     idle_limit_wdata
);
	import igfr_pkg::*;

	logic f_valid;
	logic q_ready;
	op_t  f_op;
	logic q_valid;
	logic q_pop;
	op_t  q_op;

	igfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.op_valid   (f_valid),
		.op_ready   (q_ready),
		.op         (f_op)
	);

	igfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_valid),
		.ready   (q_ready),
		.push_op (f_op),
		.valid   (q_valid),
		.pop     (q_pop),
		.pop_op  (q_op)
	);

	igfr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.op_valid         (q_valid),
		.op_pop           (q_pop),
		.op               (q_op),
		.idle_limit_we    (idle_limit_we),
		.idle_limit_wdata (idle_limit_wdata),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.res              (res)
	);

endmodule

[tb/frame_rx_checker.sv]
module frame_rx_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_stall,
	input  igfr_pkg::item_t item,
	input  logic            res_valid,
	input  logic            res_stall,
	input  igfr_pkg::res_t  res,
	input  logic            idle_limit_we,
	input  logic [7:0]      idle_limit_wdata,
	output int              fails,
	output int              outstanding,
	output int              notices_seen,
	output int              bytes_seen
);
	import igfr_pkg::*;

	logic [7:0] frame_bytes [BUFFER_DEPTH];
	int         held;
	int         count_at_tick;
	int         idle_ms;
	logic [7:0] limit_ms;
	int         fail_tally;
	int         notice_tally;
	int         byte_tally;
	res_t       awaited_res [$];

	task automatic push_result(input logic k, input logic [7:0] d, input int flen,
			input logic lst);
		res_t r;
		r.kind         = k;
		r.data         = d;
		r.frame_length = FLEN_W'(flen);
		r.last         = lst;
		awaited_res.push_back(r);
	endtask

	task automatic step_frame_state(input item_t it);
		int n;
		case (it.cmd)
		CMD_BYTE: begin
			// drop the beat once the store is full
			if (held < BUFFER_DEPTH) begin
				frame_bytes[held] = it.rx_byte;
				held++;
			end
		end
		CMD_TICK: begin
			if (held == 0) begin
				count_at_tick = 0;
			end else if (count_at_tick != held) begin
				count_at_tick = held;
				idle_ms = 0;
			end else if (idle_ms < limit_ms) begin
				idle_ms += it.tick_ms;
				if (idle_ms > IDLE_MAX)
					idle_ms = IDLE_MAX;
				if (idle_ms >= limit_ms)
					push_result(RES_NOTICE, 8'd0, held, 1'b1);
			end
		end
		CMD_READ: begin
			n = (it.read_limit < held) ? it.read_limit : held;
			for (int i = 0; i < n; i++)
				push_result(RES_DATA, frame_bytes[i], 0, i == n - 1);
			held = 0;
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			held          = 0;
			count_at_tick = 0;
			idle_ms       = 0;
			limit_ms      = IDLE_RESET;
			fail_tally    = 0;
			notice_tally  = 0;
			byte_tally    = 0;
			awaited_res.delete();
			fails        <= 0;
			outstanding  <= 0;
			notices_seen <= 0;
			bytes_seen   <= 0;
		end else begin
			if (idle_limit_we)
				limit_ms = idle_limit_wdata;
			if (item_valid && !item_stall)
				step_frame_state(item);
			if (res_valid && !res_stall) begin
				if (awaited_res.size() == 0) begin
					$display("%0t: result with nothing expected: kind %0d data %02h len %0d last %0d",
						$time, res.kind, res.data, res.frame_length, res.last);
					fail_tally++;
				end else begin
					want = awaited_res.pop_front();
					if (want.kind != res.kind || want.data != res.data ||
							want.frame_length != res.frame_length || want.last != res.last) begin
						$display("%0t: mismatch: expected kind %0d data %02h len %0d last %0d",
							$time, want.kind, want.data, want.frame_length, want.last);
						$display("%0t:           got kind %0d data %02h len %0d last %0d",
							$time, res.kind, res.data, res.frame_length, res.last);
						fail_tally++;
					end
				end
				if (res.kind == RES_NOTICE)
					notice_tally++;
				else
					byte_tally++;
			end
			fails        <= fail_tally;
			outstanding  <= awaited_res.size();
			notices_seen <= notice_tally;
			bytes_seen   <= byte_tally;
		end
	end

endmodule

[tb/testbench.sv]
module testbench;
	import igfr_pkg::*;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         PHASE_ITEMS   = 40;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       res_valid;
	logic       res_stall;
	res_t       res;
	logic       idle_limit_we;
	logic [7:0] idle_limit_wdata;

	int fails;
	int outstanding;
	int notices_seen;
	int bytes_seen;
	int idle_mode;
	bit long_hold;
	int beats_sent;
	int beats_ignored;

	idle_gap_frame_receiver dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.item             (item),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.res              (res),
		.idle_limit_we    (idle_limit_we),
		.idle_limit_wdata (idle_limit_wdata)
	);

	frame_rx_checker rx_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.item             (item),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.res              (res),
		.idle_limit_we    (idle_limit_we),
		.idle_limit_wdata (idle_limit_wdata),
		.fails            (fails),
		.outstanding      (outstanding),
		.notices_seen     (notices_seen),
		.bytes_seen       (bytes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls per idling mode, or one long counted hold-off
	initial begin
		int held_cycles;
		int stall_pct;
		held_cycles = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res_stall <= 1'b1;
				held_cycles++;
				if (held_cycles == HOLD_CYCLES) begin
					long_hold   = 1'b0;
					held_cycles = 0;
				end
			end else begin
				stall_pct = (idle_mode == 2) ? 85 : (idle_mode == 3) ? 11 : 0;
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic item_t make_item(input logic [1:0] op, input logic [7:0] val);
		item_t it;
		it.cmd        = op;
		it.rx_byte    = 8'($urandom);
		it.tick_ms    = 8'($urandom);
		it.read_limit = 8'($urandom);
		case (op)
		CMD_BYTE: it.rx_byte    = val;
		CMD_TICK: it.tick_ms    = val;
		CMD_READ: it.read_limit = val;
		default: ;
		endcase
		return it;
	endfunction

	task automatic offer(input item_t it);
		int gap_pct;
		gap_pct = (idle_mode == 1) ? 85 : (idle_mode == 3) ? 11 : 0;
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
		if (it.cmd == CMD_UNUSED)
			beats_ignored++;
	endtask

	// hold the sender until every expected beat is back, then let the pipe empty
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		idle_limit_we    <= 1'b1;
		idle_limit_wdata <= v;
		@(posedge clk);
		idle_limit_we <= 1'b0;
	endtask

	// mostly burst, ticks, read; a slice of stray commands
	task automatic random_frame();
		int burst;
		int ticks;
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			offer(make_item(2'($urandom_range(3)), 8'($urandom)));
		end else begin
			burst = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
			for (int i = 0; i < burst; i++)
				offer(make_item(CMD_BYTE, 8'($urandom)));
			ticks = $urandom_range(1, 5);
			for (int i = 0; i < ticks; i++)
				offer(make_item(CMD_TICK, 8'($urandom_range(1) ? $urandom_range(20)
					: $urandom_range(255))));
			roll = $urandom_range(99);
			if (roll < 10)
				offer(make_item(CMD_READ, 8'd0));
			else if (roll < 40)
				offer(make_item(CMD_READ, 8'($urandom_range(burst))));
			else if (roll < 85)
				offer(make_item(CMD_READ, 8'($urandom_range(255))));
		end
	endtask

	task automatic random_phase(input int mode, input logic [7:0] limit);
		int goal;
		idle_mode = mode;
		write_limit(limit);
		goal = beats_sent - beats_ignored + PHASE_ITEMS;
		while (beats_sent - beats_ignored < goal)
			random_frame();
		settle();
	endtask

	initial begin
		arst_n           = 1'b0;
		item_valid       = 1'b0;
		item             = '0;
		idle_limit_we    = 1'b0;
		idle_limit_wdata = '0;
		idle_mode        = 0;
		long_hold        = 1'b0;
		beats_sent       = 0;
		beats_ignored    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit of 30
		offer(make_item(CMD_TICK, 8'd0));
		offer(make_item(CMD_BYTE, 8'h00));
		offer(make_item(CMD_BYTE, 8'hFF));
		offer(make_item(CMD_TICK, 8'd0));
		offer(make_item(CMD_TICK, 8'd10));
		offer(make_item(CMD_TICK, 8'd255));
		offer(make_item(CMD_TICK, 8'd5));
		offer(make_item(CMD_READ, 8'd1));
		// refill to the old snapshot: timer must not restart
		offer(make_item(CMD_BYTE, 8'h5A));
		offer(make_item(CMD_BYTE, 8'hA5));
		offer(make_item(CMD_TICK, 8'd1));
		offer(make_item(CMD_READ, 8'd255));
		offer(make_item(CMD_READ, 8'd0));
		offer('{cmd: CMD_UNUSED, rx_byte: 8'hFF, tick_ms: 8'hFF, read_limit: 8'hFF});
		offer(make_item(CMD_TICK, 8'd255));
		offer(make_item(CMD_BYTE, 8'h3C));
		offer(make_item(CMD_TICK, 8'd0));
		offer(make_item(CMD_TICK, 8'd29));
		offer(make_item(CMD_TICK, 8'd1));
		offer(make_item(CMD_READ, 8'd255));
		settle();

		// notice at a limit of 1, then raise the limit above the timer
		write_limit(8'd1);
		offer(make_item(CMD_BYTE, 8'h81));
		offer(make_item(CMD_TICK, 8'd0));
		offer(make_item(CMD_TICK, 8'd7));
		settle();
		write_limit(8'd200);
		offer(make_item(CMD_TICK, 8'd100));
		offer(make_item(CMD_TICK, 8'd100));
		offer(make_item(CMD_READ, 8'd2));
		settle();

		random_phase(0, IDLE_RESET);
		random_phase(1, 8'd1);
		random_phase(2, IDLE_MAX);
		random_phase(3, 8'd0);
		random_phase(3, 8'($urandom_range(2, 254)));

		// long output hold-off while the sender keeps pushing full frames
		idle_mode = 0;
		long_hold = 1'b1;
		for (int i = 0; i < 34; i++)
			offer(make_item(CMD_BYTE, 8'($urandom)));
		offer(make_item(CMD_READ, 8'd255));
		for (int i = 0; i < 10; i++)
			offer(make_item(CMD_BYTE, 8'($urandom)));
		offer(make_item(CMD_TICK, 8'd0));
		offer(make_item(CMD_TICK, 8'd255));
		offer(make_item(CMD_READ, 8'd255));
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 5; i++)
				offer(make_item(CMD_BYTE, 8'($urandom)));
			offer(make_item(CMD_READ, 8'd255));
		end
		settle();

		$display("Sent %0d item beats (%0d unused commands); checked %0d notices, %0d read bytes",
			beats_sent, beats_ignored, notices_seen, bytes_seen);
		$display("Idle limits 0, 1, 30, 200, 255 and one random; store overflow; %0d-cycle hold",
			HOLD_CYCLES);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
